@@ design/pks2u_pkg.sv @@
package pks2u_pkg;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int BUF_BYTES  = 9;
  localparam int BUF_W      = BUF_BYTES * 8;
  localparam int CNT_W      = 4;

  localparam logic [15:0] KEY_BACKSPACE = 16'hff08;
  localparam logic [15:0] KEY_H         = 16'h0048;
  localparam logic [15:0] KEY_G         = 16'h0047;
  localparam logic [15:0] KEY_R         = 16'h0052;
  localparam logic [15:0] KEY_Y         = 16'h0059;
  localparam logic [15:0] KEY_ASCII_END = 16'h0080;

  localparam logic [7:0] UTF_LEAD_SIN  = 8'he0;
  localparam logic [7:0] UTF_SIN_LO    = 8'hb6;
  localparam logic [7:0] UTF_SIN_HI    = 8'hb7;
  localparam logic [7:0] UTF_LEAD_PUNC = 8'he2;
  localparam logic [7:0] UTF_PUNC_MID  = 8'h80;
  localparam logic [7:0] UTF_ZWNJ_LO   = 8'h8c;
  localparam logic [7:0] UTF_ZWJ_LO    = 8'h8d;
  localparam logic [7:0] CODE_ZWNJ     = 8'h0c;
  localparam logic [7:0] CODE_ZWJ      = 8'h0d;
  localparam logic [7:0] CODE_HI_BIT   = 8'h40;
  localparam logic [7:0] CODE_LO_MASK  = 8'h3f;
  localparam logic [7:0] CONS_FIRST    = 8'h9a;
  localparam logic [7:0] CONS_LAST     = 8'hc6;

  // Byte sequences, first emitted byte in the lowest bits.
  localparam logic [BUF_W-1:0] RAKA_BYTES  = 72'hbb_b6_e0_8d_80_e2_8a_b7_e0;
  localparam logic [BUF_W-1:0] YANSA_BYTES = 72'h00_00_00_ba_b6_e0_8a_b7_e0;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } cons_key_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] mp;
    logic [7:0] sg;
  } cons_code_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] s0;
    logic [7:0] d0;
    logic [7:0] s1;
    logic [7:0] d1;
  } vow_t;

  typedef struct packed {
    logic        ok;
    logic [23:0] bytes;
  } enc_t;

  function automatic cons_key_t cons_by_key(input logic [15:0] k);
    cons_key_t r;
    r.hit = (k[15:8] == 8'h00);
    r.ch  = 8'h00;
    case (k[7:0])
      "q": r.ch = 8'ha4;
      "Q": r.ch = 8'ha5;
      "w": r.ch = 8'hca;
      "W": r.ch = 8'h0c;
      "r", "R": r.ch = 8'hbb;
      "t": r.ch = 8'had;
      "T": r.ch = 8'ha7;
      "y", "Y": r.ch = 8'hba;
      "p": r.ch = 8'hb4;
      "P": r.ch = 8'hb5;
      "s": r.ch = 8'hc3;
      "S": r.ch = 8'hc1;
      "d": r.ch = 8'haf;
      "D": r.ch = 8'ha9;
      "f", "F": r.ch = 8'hc6;
      "g": r.ch = 8'h9c;
      "G": r.ch = 8'h9f;
      "h", "H": r.ch = 8'hc4;
      "j": r.ch = 8'ha2;
      "J": r.ch = 8'ha3;
      "k": r.ch = 8'h9a;
      "K": r.ch = 8'h9b;
      "l": r.ch = 8'hbd;
      "L": r.ch = 8'hc5;
      "z": r.ch = 8'h8f;
      "Z": r.ch = 8'h90;
      "x": r.ch = 8'h82;
      "X": r.ch = 8'h9e;
      "c": r.ch = 8'ha0;
      "C": r.ch = 8'ha1;
      "v", "V": r.ch = 8'hc0;
      "b": r.ch = 8'hb6;
      "B": r.ch = 8'hb7;
      "n": r.ch = 8'hb1;
      "N": r.ch = 8'hab;
      "m": r.ch = 8'hb8;
      "M": r.ch = 8'hb9;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // Aspirate and nasal forms of the first consonant entry that holds the code.
  function automatic cons_code_t cons_by_code(input logic [7:0] c);
    cons_code_t r;
    r.hit = 1'b1;
    r.mp  = 8'h00;
    r.sg  = 8'h00;
    case (c)
      8'ha4, 8'ha5, 8'hca, 8'h0c, 8'hbb, 8'hba, 8'hc6, 8'hbd, 8'hc5,
      8'h8f, 8'h90, 8'h82, 8'h9e, 8'hc0, 8'hb8: ;
      8'had, 8'hae: r.mp = 8'hae;
      8'ha7, 8'ha8: r.mp = 8'ha8;
      8'hb4, 8'hb5: r.mp = 8'hb5;
      8'hc3, 8'hc2, 8'hc1: r.mp = 8'hc2;
      8'haf, 8'hb0, 8'hb3: begin
        r.mp = 8'hb0;
        r.sg = 8'hb3;
      end
      8'ha9, 8'haa, 8'hac: begin
        r.mp = 8'haa;
        r.sg = 8'hac;
      end
      8'h9c, 8'h9d, 8'h9f: begin
        r.mp = 8'h9d;
        r.sg = 8'h9f;
      end
      8'hc4, 8'h83: r.mp = 8'h83;
      8'ha2, 8'ha3, 8'ha6: begin
        r.mp = 8'ha3;
        r.sg = 8'ha6;
      end
      8'h9a, 8'h9b: r.mp = 8'h9b;
      8'ha0, 8'ha1: r.mp = 8'ha1;
      8'hb6, 8'hb7, 8'hb9: begin
        r.mp = 8'hb7;
        r.sg = 8'hb9;
      end
      8'hb1: r.sg = 8'h82;
      8'hab: r.sg = 8'h9e;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic vow_t vow_by_key(input logic [15:0] k);
    vow_t r;
    r = '0;
    r.hit = (k[15:8] == 8'h00);
    case (k[7:0])
      "a": {r.s0, r.d0, r.s1, r.d1} = 32'h85_86_cf_cf;
      "A": {r.s0, r.d0, r.s1, r.d1} = 32'h87_88_d0_d1;
      "e", "E": {r.s0, r.d0, r.s1, r.d1} = 32'h91_92_d9_da;
      "i": {r.s0, r.d0, r.s1, r.d1} = 32'h89_8a_d2_d3;
      "I": {r.s0, r.d0, r.s1, r.d1} = 32'h93_00_db_db;
      "o": {r.s0, r.d0, r.s1, r.d1} = 32'h94_95_dc_dd;
      "O": {r.s0, r.d0, r.s1, r.d1} = 32'h96_00_de_df;
      "u": {r.s0, r.d0, r.s1, r.d1} = 32'h8b_8c_d4_d6;
      "U": {r.s0, r.d0, r.s1, r.d1} = 32'h8d_8e_d8_f2;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // UTF-8 bytes of an 8-bit code, first byte lowest. Plain codes give nothing.
  function automatic enc_t encode_code(input logic [7:0] code);
    enc_t r;
    r = '0;
    if (code[7]) begin
      r.ok = 1'b1;
      if (!code[6]) begin
        r.bytes = {code, UTF_SIN_LO, UTF_LEAD_SIN};
      end else begin
        r.bytes = {(code & CODE_LO_MASK) | UTF_PUNC_MID, UTF_SIN_HI, UTF_LEAD_SIN};
      end
    end else if (code == CODE_ZWNJ || code == CODE_ZWJ) begin
      r.ok    = 1'b1;
      r.bytes = {UTF_PUNC_MID | code, UTF_PUNC_MID, UTF_LEAD_PUNC};
    end
    return r;
  endfunction

  // Code of the character held in the three bytes before the cursor.
  function automatic logic [7:0] decode_prev(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (a == UTF_LEAD_SIN) begin
      if (b == UTF_SIN_LO) begin
        r = c;
      end else if (b == UTF_SIN_HI) begin
        r = c | CODE_HI_BIT;
      end
    end else if (a == UTF_LEAD_PUNC && b == UTF_PUNC_MID) begin
      if (c == UTF_ZWNJ_LO) begin
        r = CODE_ZWNJ;
      end else if (c == UTF_ZWJ_LO) begin
        r = CODE_ZWJ;
      end
    end
    return r;
  endfunction

endpackage

@@ design/phonetic_key_to_sinhala_utf8.sv @@
// Phonetic keyboard to Sinhala UTF-8 converter.
//
// Input stream: one beat per key event. The beat carries the keysym, the
// release and modifier flags, and the three bytes in front of the cursor.
// Output stream: one beat per committed UTF-8 byte (one to nine per key), or a
// single beat with byte_valid low when the key commits nothing. tlast marks
// the final beat of each key; handled and delete_before repeat on every beat.
//
// A key accepted into the input register is converted combinationally and
// moves into the output register once the serializer is empty or the last
// beat of the current key is taken; its first byte is then offered there.
// Throughput: one byte per cycle while out_tready is high, so a key holds the
// output serializer for its output beats (1 to 9). The input register takes the
// next key while the serializer still drains the current one, and the next key
// moves in as the last beat of the current one is taken.
//
// Reset (rst_n low, synchronous) empties both registers. When the receiver
// holds out_tready low, the current beat stays on the port unchanged, and one
// further key waits in the input register with in_tready low.
module phonetic_key_to_sinhala_utf8
  import pks2u_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // key_code[15:0], key_release[16], other_modifier[17], prev_valid[18],
  // prev_byte_a[26:19], prev_byte_b[34:27], prev_byte_c[42:35], zero pad above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // handled[0], delete_before[1], byte_valid[2], out_byte[10:3], zero pad above
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  // Input register.
  logic                 s1_valid_r;
  logic [IN_DATA_W-1:0] s1_data_r;

  // Output serializer: the remaining bytes shift down one per beat.
  logic             s2_valid_r;
  logic [BUF_W-1:0] s2_buf_r;
  logic [CNT_W-1:0] s2_cnt_r;
  logic             s2_bv_r;
  logic             s2_hand_r;
  logic             s2_del_r;

  logic s2_last;
  logic s2_load;
  logic in_beat;
  logic out_beat;

  // Fields of the held key.
  logic [15:0] key;
  logic        key_rel;
  logic        key_mod;
  logic        pv;
  logic [7:0]  prev;

  // Conversion result.
  cons_key_t        ck;
  cons_code_t       cc;
  vow_t             vk;
  enc_t             enc;
  logic             l1;
  logic             use_code;
  logic [7:0]       code;
  logic             handled;
  logic             del;
  logic [BUF_W-1:0] cbuf;
  logic [CNT_W-1:0] n;

  assign key     = s1_data_r[15:0];
  assign key_rel = s1_data_r[16];
  assign key_mod = s1_data_r[17];
  assign pv      = s1_data_r[18];
  assign prev    = pv ? decode_prev(s1_data_r[26:19], s1_data_r[34:27], s1_data_r[42:35])
                      : 8'h00;

  assign ck  = cons_by_key(key);
  assign vk  = vow_by_key(key);
  assign cc  = cons_by_code(prev);
  // Modifier keys only act on a known consonant before the cursor.
  assign l1  = cc.hit && (prev != 8'h00);

  always_comb begin
    handled  = 1'b0;
    del      = 1'b0;
    use_code = 1'b0;
    code     = 8'h00;
    cbuf     = '0;
    n        = '0;
    if (!key_rel && !key_mod && key != 16'h0000) begin
      if (ck.hit) begin
        handled = 1'b1;
        if (l1 && key == KEY_H && cc.mp != 8'h00) begin
          del      = 1'b1;
          use_code = 1'b1;
          code     = cc.mp;
        end else if (l1 && key == KEY_G && cc.sg != 8'h00) begin
          del      = 1'b1;
          use_code = 1'b1;
          code     = cc.sg;
        end else if (l1 && key == KEY_R) begin
          cbuf = RAKA_BYTES;
          n    = CNT_W'(9);
        end else if (l1 && key == KEY_Y) begin
          cbuf = YANSA_BYTES;
          n    = CNT_W'(6);
        end else begin
          use_code = 1'b1;
          code     = ck.ch;
        end
      end else if (vk.hit) begin
        handled  = 1'b1;
        use_code = 1'b1;
        // After a consonant the vowel takes its sign form; a repeated vowel
        // replaces the one before the cursor with its long form.
        if (prev inside {[CONS_FIRST:CONS_LAST]}) begin
          code = vk.s1;
        end else if (pv && prev == vk.s0) begin
          del  = 1'b1;
          code = vk.d0;
        end else if (pv && prev == vk.s1) begin
          del  = 1'b1;
          code = vk.d1;
        end else begin
          code = vk.s0;
        end
      end else if (key < KEY_ASCII_END) begin
        handled = 1'b1;
        cbuf    = BUF_W'(key[7:0]);
        n       = CNT_W'(1);
      end else if (key == KEY_BACKSPACE) begin
        handled = 1'b1;
        del     = 1'b1;
      end
    end
    enc = encode_code(code);
    if (use_code && enc.ok) begin
      cbuf = BUF_W'(enc.bytes);
      n    = CNT_W'(3);
    end
  end

  assign s2_last  = (s2_cnt_r == CNT_W'(1));
  assign out_beat = s2_valid_r && out_tready;
  assign s2_load  = s1_valid_r && (!s2_valid_r || (out_tready && s2_last));
  assign in_tready = !s1_valid_r || s2_load;
  assign in_beat  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_data_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (out_beat && s2_last) begin
      s2_valid_r <= 1'b0;
    end
  end

  // A key that commits nothing still gives one beat, with byte_valid low.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_buf_r  <= cbuf;
      s2_cnt_r  <= (n == '0) ? CNT_W'(1) : n;
      s2_bv_r   <= (n != '0);
      s2_hand_r <= handled;
      s2_del_r  <= del;
    end else if (out_beat) begin
      s2_buf_r <= s2_buf_r >> 8;
      s2_cnt_r <= s2_cnt_r - CNT_W'(1);
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tlast  = s2_last;
  assign out_tdata  = {5'b0, s2_buf_r[7:0], s2_bv_r, s2_del_r, s2_hand_r};

endmodule
